// File: hw/rtl/acc_pkg.sv
package acc_pkg;

  // clock limits
  localparam int unsigned HOURS_W   = 5;
  localparam int unsigned MINUTES_W = 6;
  localparam int unsigned SECONDS_W = 6;
  localparam int unsigned VOLUME_W  = 8;
  localparam int unsigned SNOOZE_W  = 8;

  localparam logic [HOURS_W-1:0]   HOURS_PER_DAY = HOURS_W'(24);
  localparam logic [MINUTES_W-1:0] LAST_MINUTE   = MINUTES_W'(59);
  localparam logic [MINUTES_W-1:0] MINUTES_PER_H = MINUTES_W'(60);

  // volume limits and step
  localparam logic [VOLUME_W-1:0] VOLUME_MIN  = VOLUME_W'(31);
  localparam logic [VOLUME_W-1:0] VOLUME_MAX  = VOLUME_W'(255);
  localparam logic [VOLUME_W-1:0] VOLUME_STEP = VOLUME_W'(4);

  // reset values
  localparam logic [HOURS_W-1:0]   RST_HOURS   = HOURS_W'(23);
  localparam logic [MINUTES_W-1:0] RST_MINUTES = MINUTES_W'(59);
  localparam logic [SECONDS_W-1:0] RST_SECONDS = SECONDS_W'(56);
  localparam logic [VOLUME_W-1:0]  RST_VOLUME  = VOLUME_W'(128);
  localparam logic [SNOOZE_W-1:0]  RST_SNOOZE  = SNOOZE_W'(10);

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_SNOOZE_LENGTH = 1'b0;

  // item kinds
  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  // button codes
  localparam logic [3:0] BTN_TIME_SET  = 4'd0;
  localparam logic [3:0] BTN_ALARM_SET = 4'd1;
  localparam logic [3:0] BTN_SNOOZE    = 4'd5;
  localparam logic [3:0] BTN_ENABLE    = 4'd7;

  // encoder turn codes
  localparam logic [2:0] TURN_HOUR_UP  = 3'b001;
  localparam logic [2:0] TURN_HOUR_DN  = 3'b111;
  localparam logic [2:0] TURN_MIN_UP   = 3'b010;
  localparam logic [2:0] TURN_MIN_DN   = 3'b110;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_TIME  = 2'd1,
    MODE_ALARM = 2'd2
  } mode_t;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
  } clock_time_t;

  // add small signed deltas with carries, floor at midnight, wrap at 24 h
  function automatic clock_time_t time_add(input clock_time_t t,
                                           input logic signed [1:0] dh,
                                           input logic signed [1:0] dm,
                                           input logic signed [1:0] ds);
    logic signed [7:0] hh;
    logic signed [7:0] mm;
    logic signed [7:0] ss;
    clock_time_t       res;
    hh = $signed({3'b000, t.hours})   + 8'(dh);
    mm = $signed({2'b00,  t.minutes}) + 8'(dm);
    ss = $signed({2'b00,  t.seconds}) + 8'(ds);
    if (ss > $signed({2'b00, LAST_MINUTE})) begin
      mm = mm + 8'sd1;
      ss = ss - $signed({2'b00, MINUTES_PER_H});
    end else if (ss < 8'sd0) begin
      mm = mm - 8'sd1;
      ss = ss + $signed({2'b00, MINUTES_PER_H});
    end
    if (mm > $signed({2'b00, LAST_MINUTE})) begin
      hh = hh + 8'sd1;
      mm = mm - $signed({2'b00, MINUTES_PER_H});
    end else if (mm < 8'sd0) begin
      hh = hh - 8'sd1;
      mm = mm + $signed({2'b00, MINUTES_PER_H});
    end
    if (hh < 8'sd0) begin
      hh = 8'sd0;
      mm = 8'sd0;
      ss = 8'sd0;
    end
    if (hh >= $signed({3'b000, HOURS_PER_DAY})) begin
      hh = hh - $signed({3'b000, HOURS_PER_DAY});
    end
    res.hours   = hh[HOURS_W-1:0];
    res.minutes = mm[MINUTES_W-1:0];
    res.seconds = ss[SECONDS_W-1:0];
    return res;
  endfunction

endpackage

// File: hw/rtl/alarm_clock_controller.sv
// Twenty-four-hour alarm clock controller.
// in_ channel: one word per event. in_tuser is the event kind (tick or
// control scan); in_tdata carries the button code and the encoder turn.
// out_ channel: one word per input word, the clock state after that event:
// current time, alarm time, mode, enable, sounding flag and speaker volume.
// cfg_ port: APB-style, one register (snooze length) at byte address 0; it must be
// written only while no event is in flight, which the block does not enforce.
// An accepted word is captured in an input register; the state update from
// there is combinational and its result is written into the output register
// when that register is empty or being drained.
// Throughput: one word per cycle while the receiver takes results; the
// combinational state update between the input and output registers sets that figure.
// Reset (synchronous, rst_n low) sets the time to 23:59:56, the alarm to
// 23:59, run mode, disarmed, volume 128 and snooze length 10; no word is
// held.
// When the receiver stalls, the output register holds its word and the
// input register can still take one more word before in_tready drops.
module alarm_clock_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: button[3:0], encoder_turn[6:4], zero pad[7]
  input  logic [7:0]                     in_tdata,
  // in_tuser: action[0]
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: hours[4:0], minutes[10:5], seconds[16:11], wake_hours[21:17],
  // wake_minutes[27:22], set_mode[29:28], alarm_enabled[30],
  // alarm_sounding[31], volume_drive[39:32]
  output logic [39:0]                    out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [acc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import acc_pkg::*;

  logic [SNOOZE_W-1:0] snooze_length;

  // input register
  logic       in_valid_r;
  logic       in_action_r;
  logic [3:0] in_button_r;
  logic [2:0] in_turn_r;

  // clock state
  clock_time_t          cur_r,       cur_nxt;
  logic [HOURS_W-1:0]   alarm_h_r,   alarm_h_nxt;
  logic [MINUTES_W-1:0] alarm_m_r,   alarm_m_nxt;
  mode_t                mode_r,      mode_nxt;
  logic                 armed_r,     armed_nxt;
  logic                 trig_r,      trig_nxt;
  logic [SNOOZE_W-1:0]  snooze_r,    snooze_nxt;
  logic [VOLUME_W-1:0]  volume_r,    volume_nxt;

  // output register
  logic        out_valid_r;
  logic [39:0] out_data_r, out_data_nxt;

  logic advance;
  logic fire;

  clock_time_t       alarm_sum;
  clock_time_t       alarm_in;
  clock_time_t       cur_step;
  logic signed [1:0] dh;
  logic signed [1:0] dm;
  logic signed [9:0] vol_s;
  logic              on;

  acc_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .snooze_length (snooze_length)
  );

  // handshake
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_action_r <= in_tuser;
      in_button_r <= in_tdata[3:0];
      in_turn_r   <= in_tdata[6:4];
    end
  end

  // state update for the held word
  always_comb begin
    cur_nxt     = cur_r;
    alarm_h_nxt = alarm_h_r;
    alarm_m_nxt = alarm_m_r;
    mode_nxt    = mode_r;
    armed_nxt   = armed_r;
    trig_nxt    = trig_r;
    snooze_nxt  = snooze_r;
    volume_nxt  = volume_r;
    dh          = 2'sd0;
    dm          = 2'sd0;
    vol_s       = $signed({2'b00, volume_r});
    alarm_in.hours   = alarm_h_r;
    alarm_in.minutes = alarm_m_r;
    alarm_in.seconds = '0;
    alarm_sum   = alarm_in;
    cur_step    = cur_r;

    // turn decode
    case (in_turn_r)
      TURN_HOUR_UP: dh = 2'sd1;
      TURN_HOUR_DN: dh = -2'sd1;
      TURN_MIN_UP:  dm = 2'sd1;
      TURN_MIN_DN:  dm = -2'sd1;
      default: ;
    endcase

    if (in_action_r == ACTION_TICK) begin
      // one second tick
      if (snooze_r != '0) begin
        snooze_nxt = snooze_r - SNOOZE_W'(1);
      end
      cur_step = time_add(cur_r, 2'sd0, 2'sd0, 2'sd1);
      cur_nxt  = cur_step;
      if (armed_r && (cur_step.hours == alarm_h_r) && (cur_step.minutes == alarm_m_r)) begin
        trig_nxt = 1'b1;
      end
    end else begin
      // button first
      unique case (in_button_r)
        BTN_TIME_SET:  mode_nxt = (mode_r == MODE_TIME) ? MODE_RUN : MODE_TIME;
        BTN_ALARM_SET: mode_nxt = (mode_r == MODE_ALARM) ? MODE_RUN : MODE_ALARM;
        BTN_SNOOZE:    snooze_nxt = snooze_length;
        BTN_ENABLE:    armed_nxt = !armed_r;
        default: ;
      endcase
      if (!armed_nxt) begin
        trig_nxt = 1'b0;
      end

      // then the encoder, by the new mode
      unique case (mode_nxt)
        MODE_TIME: begin
          if ((dh != 2'sd0) || (dm != 2'sd0)) begin
            cur_step = time_add(cur_r, dh, dm, 2'sd0);
            cur_nxt  = cur_step;
          end
        end
        MODE_ALARM: begin
          if ((dh != 2'sd0) || (dm != 2'sd0)) begin
            alarm_sum   = time_add(alarm_in, dh, dm, 2'sd0);
            alarm_h_nxt = alarm_sum.hours;
            alarm_m_nxt = alarm_sum.minutes;
          end
        end
        default: begin
          if (in_turn_r == TURN_MIN_UP) begin
            vol_s = vol_s + $signed({2'b00, VOLUME_STEP});
          end else if (in_turn_r == TURN_MIN_DN) begin
            vol_s = vol_s - $signed({2'b00, VOLUME_STEP});
          end
          if (vol_s < $signed({2'b00, VOLUME_MIN})) begin
            vol_s = $signed({2'b00, VOLUME_MIN});
          end
          if (vol_s > $signed({2'b00, VOLUME_MAX})) begin
            vol_s = $signed({2'b00, VOLUME_MAX});
          end
          volume_nxt = vol_s[VOLUME_W-1:0];
        end
      endcase
    end

    // result word
    on = armed_nxt && trig_nxt;
    out_data_nxt = {
      on ? volume_nxt : VOLUME_W'(1),
      on && (snooze_nxt == '0),
      armed_nxt,
      mode_nxt,
      alarm_m_nxt,
      alarm_h_nxt,
      cur_nxt.seconds,
      cur_nxt.minutes,
      cur_nxt.hours
    };
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.hours   <= RST_HOURS;
      cur_r.minutes <= RST_MINUTES;
      cur_r.seconds <= RST_SECONDS;
      alarm_h_r     <= RST_HOURS;
      alarm_m_r     <= RST_MINUTES;
      mode_r        <= MODE_RUN;
      armed_r       <= 1'b0;
      trig_r        <= 1'b0;
      snooze_r      <= '0;
      volume_r      <= RST_VOLUME;
    end else if (fire) begin
      cur_r         <= cur_nxt;
      alarm_h_r     <= alarm_h_nxt;
      alarm_m_r     <= alarm_m_nxt;
      mode_r        <= mode_nxt;
      armed_r       <= armed_nxt;
      trig_r        <= trig_nxt;
      snooze_r      <= snooze_nxt;
      volume_r      <= volume_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/acc_regs.sv
module acc_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [acc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  output logic [acc_pkg::SNOOZE_W-1:0]     snooze_length
);
  import acc_pkg::*;

  logic [SNOOZE_W-1:0] snooze_length_r;
  logic                reg_idx;
  logic                wr_en;

  // word index from the byte address
  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snooze_length_r <= RST_SNOOZE;
    end else if (wr_en && (reg_idx == REG_SNOOZE_LENGTH)) begin
      snooze_length_r <= cfg_pwdata[SNOOZE_W-1:0];
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_SNOOZE_LENGTH: cfg_prdata = {{(32-SNOOZE_W){1'b0}}, snooze_length_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign snooze_length = snooze_length_r;

endmodule
